// ===== rtl/vac_pkg.sv =====
// vac_pkg: type codes, register indexes, status codes and conversion functions
// used by the vertex attribute converter; no dependencies
`default_nettype none
package vac_pkg;
	localparam int DEF_MAX_COMPONENTS = 4;
	localparam int DEF_ADDRESS_BITS   = 24;
	localparam int DEF_INDEX_BITS     = 16;

	typedef enum logic [2:0] {
		TY_U8 = 3'd0, TY_U16 = 3'd1, TY_U32 = 3'd2, TY_I8 = 3'd3,
		TY_I16 = 3'd4, TY_I32 = 3'd5, TY_F32 = 3'd6, TY_F32B = 3'd7
	} comp_type_t;

	typedef enum logic [2:0] {
		REG_SOURCE_TYPE = 3'd0, REG_TARGET_TYPE = 3'd1, REG_SOURCE_OFFSET = 3'd2,
		REG_SOURCE_STRIDE = 3'd3, REG_SOURCE_COMPS = 3'd4, REG_TARGET_COMPS = 3'd5,
		REG_SOURCE_LENGTH = 3'd6, REG_TARGET_LENGTH = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_SRC_SHORT = 2'd1, ST_DST_SHORT = 2'd2, ST_RSVD = 2'd3
	} status_t;

	// bytes per component: 1, 2 or 4
	function automatic logic [2:0] type_bytes(input logic [2:0] t);
		case (t)
			TY_U8, TY_I8:   type_bytes = 3'd1;
			TY_U16, TY_I16: type_bytes = 3'd2;
			default:        type_bytes = 3'd4;
		endcase
	endfunction

	function automatic logic type_is_float(input logic [2:0] t);
		type_is_float = (t == TY_F32) || (t == TY_F32B);
	endfunction

	function automatic logic type_is_signed(input logic [2:0] t);
		type_is_signed = (t == TY_I8) || (t == TY_I16) || (t == TY_I32);
	endfunction

	// source bits to a 33-bit two's complement integer
	function automatic logic [32:0] src_extend(input logic [31:0] raw, input logic [2:0] t);
		logic s;
		s = type_is_signed(t);
		case (type_bytes(t))
			3'd1:    src_extend = {{25{s & raw[7]}}, raw[7:0]};
			3'd2:    src_extend = {{17{s & raw[15]}}, raw[15:0]};
			default: src_extend = {s & raw[31], raw};
		endcase
	endfunction

	// integer to f32, round to nearest even
	function automatic logic [31:0] int_to_f32(input logic [32:0] v);
		logic        sgn;
		logic [31:0] m;
		logic [4:0]  p;
		logic [31:0] nrm;
		logic [24:0] mant;
		logic        rb;
		logic        st;
		logic [7:0]  ex;
		sgn = v[32];
		m = sgn ? 32'(-v) : v[31:0];
		p = 5'd0;
		for (int i = 0; i < 32; i++)
			if (m[i]) p = 5'(i);
		nrm = m << (5'd31 - p);
		rb = nrm[7];
		st = |nrm[6:0];
		mant = {1'b0, nrm[31:8]};
		if (rb && (st || mant[0])) mant = mant + 25'd1;
		ex = 8'(p) + 8'd127;
		if (mant[24]) begin
			mant = mant >> 1;
			ex = ex + 8'd1;
		end
		if (m == 32'd0) int_to_f32 = 32'd0;
		else int_to_f32 = {sgn, ex, mant[22:0]};
	endfunction

	// f32 to integer: truncate toward zero, saturate, nan to zero
	function automatic logic [31:0] f32_to_int(input logic [31:0] f, input logic [2:0] t);
		logic [7:0]  ex;
		logic [22:0] fr;
		logic        neg;
		logic [33:0] mag;
		logic [33:0] mask;
		logic [33:0] lim;
		logic [7:0]  e;
		logic [54:0] sh;
		ex = f[30:23];
		fr = f[22:0];
		neg = f[31];
		case (type_bytes(t))
			3'd1:    mask = 34'hFF;
			3'd2:    mask = 34'hFFFF;
			default: mask = 34'hFFFF_FFFF;
		endcase
		lim = (mask >> 1) + 34'd1;
		e = ex - 8'd127;
		sh = {31'd0, 1'b1, fr} << e[4:0];
		if (ex == 8'hFF || ex >= 8'd159) mag = 34'h2_0000_0000;
		else if (ex < 8'd127) mag = 34'd0;
		else mag = {2'd0, sh[54:23]};
		if (ex == 8'hFF && fr != 23'd0) f32_to_int = 32'd0;
		else if (!type_is_signed(t)) begin
			if (neg) f32_to_int = 32'd0;
			else f32_to_int = 32'((mag > mask) ? mask : mag);
		end else if (!neg)
			f32_to_int = 32'((mag > lim - 34'd1) ? lim - 34'd1 : mag);
		else
			f32_to_int = 32'((34'd0 - ((mag > lim) ? lim : mag)) & mask);
	endfunction

	function automatic logic [31:0] convert(input logic [31:0] raw,
		input logic [2:0] st, input logic [2:0] tt);
		logic [32:0] r;
		r = src_extend(raw, st);
		if (type_is_float(st))
			convert = type_is_float(tt) ? raw : f32_to_int(raw, tt);
		else if (type_is_float(tt))
			convert = int_to_f32(r);
		else case (type_bytes(tt))
			3'd1:    convert = {24'd0, r[7:0]};
			3'd2:    convert = {16'd0, r[15:0]};
			default: convert = r[31:0];
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/vertex_attribute_converter_core.sv =====
// vertex_attribute_converter_core: top level of the vertex attribute converter
// depends on vac_pkg for types and conversion functions
//
// channel | signals                                          | dir
// cfg     | cfg_valid cfg_ready cfg_index cfg_data           | in
// in      | in_valid in_ready element_index component_0..3   | in
// out     | out_valid out_ready converted_value target_address| out
//         |   component_index status last                    |
// stage 1 registers the element with its bounds checks and base address; stage 2
// converts one component per cycle, unless the output stalls, into the output
// register: one beat per component up to min(source, target components), or one error beat.
// the next element is taken while the last beat of the current one is emitted.
// a stalled output holds its beat; reset restores register defaults.
`default_nettype none
module vertex_attribute_converter_core
	import vac_pkg::*;
#(
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
	parameter int ADDRESS_BITS   = DEF_ADDRESS_BITS,
	parameter int INDEX_BITS     = DEF_INDEX_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [31:0]             cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [INDEX_BITS-1:0]   element_index,
	input  wire logic [31:0]             component_0,
	input  wire logic [31:0]             component_1,
	input  wire logic [31:0]             component_2,
	input  wire logic [31:0]             component_3,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [31:0]                  converted_value,
	output logic [ADDRESS_BITS-1:0]      target_address,
	output logic [1:0]                   component_index,
	output logic [1:0]                   status,
	output logic                         last
);
	localparam logic [2:0] MAXC = 3'(MAX_COMPONENTS);

	// configuration registers
	logic [2:0]  src_type_q, tgt_type_q, src_comps_q, tgt_comps_q;
	logic [23:0] src_offset_q, src_len_q, tgt_len_q;
	logic [7:0]  src_stride_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_type_q   <= TY_F32;
			tgt_type_q   <= TY_F32;
			src_offset_q <= '0;
			src_stride_q <= 8'd12;
			src_comps_q  <= 3'd3;
			tgt_comps_q  <= 3'd3;
			src_len_q    <= 24'hFF_FFFF;
			tgt_len_q    <= 24'hFF_FFFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_TYPE:   src_type_q   <= cfg_data[2:0];
				REG_TARGET_TYPE:   tgt_type_q   <= cfg_data[2:0];
				REG_SOURCE_OFFSET: src_offset_q <= cfg_data[23:0];
				REG_SOURCE_STRIDE: src_stride_q <= cfg_data[7:0];
				REG_SOURCE_COMPS:  src_comps_q  <= cfg_data[2:0];
				REG_TARGET_COMPS:  tgt_comps_q  <= cfg_data[2:0];
				REG_SOURCE_LENGTH: src_len_q    <= cfg_data[23:0];
				REG_TARGET_LENGTH: tgt_len_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// element checks and base address
	logic [2:0]  sc, tc, ncomp;
	logic [2:0]  ssz, tsz;
	logic [5:0]  tsize_el;
	logic [34:0] src_need;
	logic [30:0] dst_need;
	logic [1:0]  chk_status;
	logic [39:0] base_full;

	always_comb begin
		sc = (src_comps_q > MAXC) ? MAXC : src_comps_q;
		tc = (tgt_comps_q > MAXC) ? MAXC : tgt_comps_q;
		ncomp = (sc < tc) ? sc : tc;
		ssz = type_bytes(src_type_q);
		tsz = type_bytes(tgt_type_q);
		tsize_el = 6'(tsz) * 6'(tc);
		src_need = 35'(src_stride_q) * 35'(element_index) + 35'(src_offset_q)
			+ 35'(ssz) * 35'(sc);
		dst_need = 31'(tsize_el) * (31'(element_index) + 31'd1);
		if (src_need > 35'(src_len_q)) chk_status = ST_SRC_SHORT;
		else if (dst_need > 31'(tgt_len_q)) chk_status = ST_DST_SHORT;
		else chk_status = ST_OK;
		base_full = 40'(element_index) * 40'(tsize_el);
	end

	// stage 1: element register, stage 2: output beat register
	logic                    busy_s1;
	logic [1:0]              status_s1;
	logic [2:0]              n_s1, cnt_s1;
	logic [2:0]              tsz_s1;
	logic [ADDRESS_BITS-1:0] base_s1, addr_s1;
	logic [31:0]             comp_s1 [4];
	logic                    beat_last;
	logic                    adv;
	logic [31:0]             conv;

	assign beat_last = (status_s1 != ST_OK) || (cnt_s1 + 3'd1 >= n_s1);
	assign adv = busy_s1 && (!out_valid || out_ready);
	assign in_ready = !busy_s1 || (adv && beat_last);
	assign conv = convert(comp_s1[cnt_s1[1:0]], src_type_q, tgt_type_q);
	assign addr_s1 = base_s1 + ADDRESS_BITS'(cnt_s1) * ADDRESS_BITS'(tsz_s1);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			status_s1 <= chk_status;
			n_s1      <= ncomp;
			tsz_s1    <= tsz;
			base_s1   <= ADDRESS_BITS'(base_full & 40'hFF_FFFF);
			comp_s1[0] <= component_0;
			comp_s1[1] <= component_1;
			comp_s1[2] <= component_2;
			comp_s1[3] <= component_3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			cnt_s1  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_s1 <= (chk_status != ST_OK) || (ncomp != 3'd0);
				cnt_s1  <= '0;
			end else if (adv && beat_last) busy_s1 <= 1'b0;
			else if (adv) cnt_s1 <= cnt_s1 + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (status_s1 != ST_OK) begin
				converted_value <= '0;
				target_address  <= '0;
				component_index <= '0;
			end else begin
				converted_value <= conv;
				target_address  <= addr_s1;
				component_index <= cnt_s1[1:0];
			end
			status <= status_s1;
			last   <= beat_last;
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && !adv) |-> !in_ready) else $error("accepted while busy");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> last) else $error("error beat not last");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> (cnt_s1 < 3'(MAX_COMPONENTS) || status_s1 != ST_OK))
		else $error("component count out of range");
endmodule
`default_nettype wire
